[hw/rtl/nsfc_pkg.sv]
`default_nettype none

package nsfc_pkg;

    localparam int POS_W       = 8;
    localparam int MAX_LEN_DEF = 128;
    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 2;
    localparam int OUT_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
    localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_C      = 8'h43;

    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GGA   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RMC   = 2'd2;

    typedef enum logic [3:0] {
        HEX_NONE = 4'b0001,
        HEX_ONE  = 4'b0010,
        HEX_DONE = 4'b0100,
        HEX_BAD  = 4'b1000
    } hex_state_t;

    typedef struct packed {
        logic       gga_match;
        logic       rmc_match;
        logic       star_seen;
        logic       two_after_star;
        hex_state_t hex_state;
        logic [7:0] hex_value;
        logic [7:0] running_xor;
    } nsfc_rec_t;

    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/nsfc_front.sv]
`default_nettype none

module nsfc_front #(
    parameter int MAX_LEN = nsfc_pkg::MAX_LEN_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_accept,
    input  wire logic [nsfc_pkg::BYTE_W-1:0] in_byte,
    output logic                             push,
    output nsfc_pkg::nsfc_rec_t              push_rec
);
    import nsfc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       xor_reg, xor_next;
    logic             star_reg, star_next;
    logic [1:0]       after_reg, after_next;
    logic [7:0]       hex_reg, hex_next;
    hex_state_t       hst_reg, hst_next;
    logic             gga_reg, gga_next;
    logic             rmc_reg, rmc_next;
    logic [4:0]       digit;
    logic             is_open;
    logic             gga_ok, rmc_ok;

    always_comb
    begin
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        star_next  = star_reg;
        after_next = after_reg;
        hex_next   = hex_reg;
        hst_next   = hst_reg;
        gga_next   = gga_reg;
        rmc_next   = rmc_reg;
        push       = 1'b0;
        digit      = hex_digit(in_byte);
        is_open    = (pos_reg != '0) && (pos_reg < POS_W'(MAX_LEN));
        gga_ok     = 1'b1;
        rmc_ok     = 1'b1;
        case (pos_reg)
            POS_W'(1):
            begin
                gga_ok = (in_byte == CH_G);
                rmc_ok = gga_ok;
            end
            POS_W'(2):
            begin
                gga_ok = (in_byte == CH_P) || (in_byte == CH_N);
                rmc_ok = gga_ok;
            end
            POS_W'(3):
            begin
                gga_ok = (in_byte == CH_G);
                rmc_ok = (in_byte == CH_R);
            end
            POS_W'(4):
            begin
                gga_ok = (in_byte == CH_G);
                rmc_ok = (in_byte == CH_M);
            end
            POS_W'(5):
            begin
                gga_ok = (in_byte == CH_A);
                rmc_ok = (in_byte == CH_C);
            end
            default:
            begin
                gga_ok = 1'b1;
                rmc_ok = 1'b1;
            end
        endcase

        if (in_accept)
        begin
            if (in_byte == CH_DOLLAR)
            begin
                pos_next   = POS_W'(1);
                xor_next   = '0;
                star_next  = 1'b0;
                after_next = '0;
                hex_next   = '0;
                hst_next   = HEX_NONE;
                gga_next   = 1'b1;
                rmc_next   = 1'b1;
            end
            else if (!is_open)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                gga_next = gga_reg && gga_ok;
                rmc_next = rmc_reg && rmc_ok;
                if (star_reg)
                begin
                    if (after_reg != 2'd2)
                    begin
                        after_next = after_reg + 2'd1;
                    end
                    case (hst_reg)
                        HEX_NONE:
                        begin
                            if (digit[4])
                            begin
                                hex_next = {4'd0, digit[3:0]};
                                hst_next = HEX_ONE;
                            end
                            else
                            begin
                                hst_next = HEX_BAD;
                            end
                        end
                        HEX_ONE:
                        begin
                            if (digit[4])
                            begin
                                hex_next = {hex_reg[3:0], digit[3:0]};
                            end
                            hst_next = HEX_DONE;
                        end
                        default:
                        begin
                            hst_next = hst_reg;
                        end
                    endcase
                end
                else if (in_byte == CH_STAR)
                begin
                    star_next = 1'b1;
                end
                else if (in_byte != CH_NL)
                begin
                    xor_next = xor_reg ^ in_byte;
                end
                if (in_byte == CH_NL)
                begin
                    push     = 1'b1;
                    pos_next = '0;
                end
            end
        end

        push_rec.gga_match      = gga_next;
        push_rec.rmc_match      = rmc_next;
        push_rec.star_seen      = star_next;
        push_rec.two_after_star = (after_next == 2'd2);
        push_rec.hex_state      = hst_next;
        push_rec.hex_value      = hex_next;
        push_rec.running_xor    = xor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            xor_reg   <= '0;
            star_reg  <= 1'b0;
            after_reg <= '0;
            hex_reg   <= '0;
            hst_reg   <= HEX_NONE;
            gga_reg   <= 1'b0;
            rmc_reg   <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            star_reg  <= star_next;
            after_reg <= after_next;
            hex_reg   <= hex_next;
            hst_reg   <= hst_next;
            gga_reg   <= gga_next;
            rmc_reg   <= rmc_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/nsfc_queue.sv]
`default_nettype none

module nsfc_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  nsfc_pkg::nsfc_rec_t       push_rec,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      head_valid,
    output nsfc_pkg::nsfc_rec_t       head_rec
);
    import nsfc_pkg::*;

    nsfc_rec_t  slot_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_rec   = slot_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = do_push ? !wr_reg : wr_reg;
        rd_next  = do_pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/nsfc_back.sv]
`default_nettype none

module nsfc_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             head_valid,
    input  nsfc_pkg::nsfc_rec_t                   head_rec,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [nsfc_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import nsfc_pkg::*;

    logic                   valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;
    logic [KIND_W-1:0]      kind;
    logic                   hex_ok;
    logic                   ok;
    logic [7:0]             rcv;

    always_comb
    begin
        pop    = head_valid && (!valid_reg || m_tready);
        kind   = head_rec.gga_match ? KIND_GGA :
                 (head_rec.rmc_match ? KIND_RMC : KIND_OTHER);
        hex_ok = (head_rec.hex_state == HEX_ONE) || (head_rec.hex_state == HEX_DONE);
        rcv    = hex_ok ? head_rec.hex_value : 8'd0;
        ok     = head_rec.star_seen && head_rec.two_after_star && hex_ok
                 && (head_rec.running_xor == head_rec.hex_value);
        data_next  = data_reg;
        valid_next = valid_reg;
        if (pop)
        begin
            data_next  = {5'd0, rcv, head_rec.running_xor, ok, kind};
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

[hw/rtl/nsfc_sentence_framer_checksum.sv]
// NMEA sentence framer and checksum checker.
// Input stream (s_*): one received UART byte per word in s_tdata[7:0].
// Output stream (m_*): one word per accepted newline inside an open sentence:
//   [1:0] sentence kind (0 other, 1 GGA, 2 RMC), [2] checksum ok,
//   [10:3] computed XOR, [18:11] received hex checksum, upper bits zero.
// Other bytes give no output word; a '$' always opens a new sentence and a
// byte outside an open sentence, or past MAX_LEN bytes, closes it silently.
// Throughput: one byte per cycle while the queue is not full (s_tready high).
// The result record is written into the two-word queue when the newline is
// taken, and passes from there into the output register.
// When the receiver stalls, results collect in the queue and output
// register; s_tready falls only once the queue is full, and bytes that give
// no result still need a free slot. Reset closes any open sentence and
// empties the queue and output register.
`default_nettype none

module nmea_sentence_framer_checksum #(
    parameter int MAX_LEN = nsfc_pkg::MAX_LEN_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [nsfc_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [1:0] sentence_kind, [2] checksum_ok, [10:3] computed_checksum,
    // [18:11] received_checksum, [23:19] zero
    output logic [nsfc_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import nsfc_pkg::*;

    logic      accept;
    logic      push;
    nsfc_rec_t push_rec;
    logic      full;
    logic      pop;
    logic      head_valid;
    nsfc_rec_t head_rec;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    nsfc_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (accept),
        .in_byte   (s_tdata),
        .push      (push),
        .push_rec  (push_rec)
    );

    nsfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    nsfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef SYNTH
    a_push_on_newline: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (accept && s_tdata == CH_NL))
        else $error("result pushed without an accepted newline");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full queue");

    a_valid_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(head_valid))
        else $error("output word without a queued result");

    a_ok_means_match: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[10:3] == m_tdata[18:11]))
        else $error("checksum ok with differing values");
`endif

endmodule

`default_nettype wire

[test/nmea_sentence_framer_checksum_tb.sv]
`default_nettype none

module nmea_sentence_framer_checksum_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import nsfc_pkg::*;

    localparam int MAX_LEN      = MAX_LEN_DEF;
    localparam int RANDOM_BYTES = 1470;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              sum_ok;
        logic [7:0]        computed;
        logic [7:0]        received;
    } checksum_verdict_t;

    class nmea_sentence_board;
        int unsigned         pos;
        logic [7:0]          xor_acc;
        bit                  star;
        int unsigned         after_star;
        logic [7:0]          hex_val;
        hex_state_t          hex_st;
        bit                  gga_live;
        bit                  rmc_live;
        checksum_verdict_t   expected_verdicts[$];
        int                  errors;

        function new();
            pos        = 0;
            xor_acc    = 8'h00;
            star       = 1'b0;
            after_star = 0;
            hex_val    = 8'h00;
            hex_st     = HEX_NONE;
            gga_live   = 1'b0;
            rmc_live   = 1'b0;
            errors     = 0;
        endfunction

        function logic [4:0] nibble_of(logic [7:0] c);
            if (c >= "0" && c <= "9")
            begin
                return {1'b1, 4'(c - "0")};
            end
            if (c >= "A" && c <= "F")
            begin
                return {1'b1, 4'(c - "A" + 8'd10)};
            end
            if (c >= "a" && c <= "f")
            begin
                return {1'b1, 4'(c - "a" + 8'd10)};
            end
            return 5'd0;
        endfunction

        function void take_byte(logic [7:0] b);
            int unsigned       slot;
            logic [4:0]        digit;
            bit                hex_ok;
            checksum_verdict_t v;
            if (b == CH_DOLLAR)
            begin
                pos        = 1;
                xor_acc    = 8'h00;
                star       = 1'b0;
                after_star = 0;
                hex_val    = 8'h00;
                hex_st     = HEX_NONE;
                gga_live   = 1'b1;
                rmc_live   = 1'b1;
                return;
            end
            if (!(pos > 0 && pos < MAX_LEN))
            begin
                pos = 0;
                return;
            end
            slot = pos;
            pos++;
            case (slot)
                1:
                begin
                    if (b != CH_G)
                    begin
                        gga_live = 1'b0;
                        rmc_live = 1'b0;
                    end
                end
                2:
                begin
                    if (b != CH_P && b != CH_N)
                    begin
                        gga_live = 1'b0;
                        rmc_live = 1'b0;
                    end
                end
                3:
                begin
                    if (b != CH_G) gga_live = 1'b0;
                    if (b != CH_R) rmc_live = 1'b0;
                end
                4:
                begin
                    if (b != CH_G) gga_live = 1'b0;
                    if (b != CH_M) rmc_live = 1'b0;
                end
                5:
                begin
                    if (b != CH_A) gga_live = 1'b0;
                    if (b != CH_C) rmc_live = 1'b0;
                end
                default: ;
            endcase
            if (star)
            begin
                if (after_star < 2) after_star++;
                digit = nibble_of(b);
                if (hex_st == HEX_NONE)
                begin
                    if (digit[4])
                    begin
                        hex_val = {4'h0, digit[3:0]};
                        hex_st  = HEX_ONE;
                    end
                    else
                    begin
                        hex_st = HEX_BAD;
                    end
                end
                else if (hex_st == HEX_ONE)
                begin
                    if (digit[4]) hex_val = {hex_val[3:0], digit[3:0]};
                    hex_st = HEX_DONE;
                end
            end
            else if (b == CH_STAR)
            begin
                star = 1'b1;
            end
            else if (b != CH_NL)
            begin
                xor_acc ^= b;
            end
            if (b != CH_NL) return;
            hex_ok     = (hex_st == HEX_ONE || hex_st == HEX_DONE);
            v.kind     = gga_live ? KIND_GGA : (rmc_live ? KIND_RMC : KIND_OTHER);
            v.sum_ok   = star && after_star >= 2 && hex_ok && xor_acc == hex_val;
            v.computed = xor_acc;
            v.received = hex_ok ? hex_val : 8'h00;
            expected_verdicts.push_back(v);
            pos = 0;
        endfunction

        function void compare_verdict(logic [OUT_TDATA_W-1:0] w);
            checksum_verdict_t v;
            if (expected_verdicts.size() == 0)
            begin
                $error("result word 0x%06h with no sentence pending", w);
                errors++;
                return;
            end
            v = expected_verdicts.pop_front();
            if (w[1:0] != v.kind)
            begin
                $error("sentence_kind: expected %0d, got %0d", v.kind, w[1:0]);
                errors++;
            end
            if (w[2] != v.sum_ok)
            begin
                $error("checksum_ok: expected %0d, got %0d", v.sum_ok, w[2]);
                errors++;
            end
            if (w[10:3] != v.computed)
            begin
                $error("computed_checksum: expected 0x%02h, got 0x%02h", v.computed, w[10:3]);
                errors++;
            end
            if (w[18:11] != v.received)
            begin
                $error("received_checksum: expected 0x%02h, got 0x%02h", v.received, w[18:11]);
                errors++;
            end
            if (w[OUT_TDATA_W-1:19] != '0)
            begin
                $error("padding: expected 0, got 0x%02h", w[OUT_TDATA_W-1:19]);
                errors++;
            end
        endfunction

        function void flag_leftovers();
            if (expected_verdicts.size() != 0)
            begin
                $error("sentence results never seen: expected %0d more, got 0",
                       expected_verdicts.size());
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [BYTE_W-1:0]        s_tdata;     // [7:0] rx_byte
    logic                     m_tvalid;
    logic                     m_tready;
    // [1:0] sentence_kind, [2] checksum_ok, [10:3] computed_checksum,
    // [18:11] received_checksum, [23:19] zero
    logic [OUT_TDATA_W-1:0]   m_tdata;

    nmea_sentence_framer_checksum #(
        .MAX_LEN(MAX_LEN)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    nmea_sentence_board sentences = new();

    int burst_left   = 0;
    int bytes_sent   = 0;
    int cycles       = 0;
    bit hold_request = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready) sentences.take_byte(s_tdata);
        if (rst_n && m_tvalid && m_tready) sentences.compare_verdict(m_tdata);
    end

    // receiver: runs of always-ready, coin-flip, mostly-ready and mostly-stalled, plus one long stall on request
    initial
    begin
        int run;
        int mode;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(1, 60);
            repeat (run)
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
        if (n < 10) return 8'("0" + n);
        return 8'((lower ? "a" : "A") + n - 10);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_nmea(input string body, input bit lower);
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = 0; i < body.len(); i++) sum ^= body[i];
        send_byte(CH_DOLLAR);
        send_text(body);
        send_byte(CH_STAR);
        send_byte(hex_char(sum[7:4], lower));
        send_byte(hex_char(sum[3:0], lower));
        send_byte(CH_NL);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sentences.expected_verdicts.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] payload_char();
        string      charset;
        logic [7:0] c;
        charset = ",.0123456789ABCDEFNSEWabcdef";
        if ($urandom_range(0, 9) == 0)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == CH_DOLLAR || c == CH_NL || c == CH_STAR);
            return c;
        end
        return charset[$urandom_range(0, charset.len() - 1)];
    endfunction

    task automatic send_random_sentence();
        logic [7:0] txt[$];
        logic [7:0] sum;
        logic [7:0] junk;
        string      hdr;
        string      bad_lead;
        int         shape;
        int         body_len;
        int         tail;
        bit         lower;
        bad_lead = "+- xXgG";
        shape    = $urandom_range(0, 9);
        case (shape)
            0, 1: hdr = "GPGGA";
            2: hdr = "GNGGA";
            3: hdr = "GPRMC";
            4: hdr = "GNRMC";
            5: hdr = "GPGSV";
            6: hdr = $urandom_range(0, 1) ? "GPGGA" : "GNRMC";
            default: hdr = "";
        endcase
        for (int i = 0; i < hdr.len(); i++) txt.push_back(hdr[i]);
        if (shape == 6)
        begin
            txt[$urandom_range(0, 4)] = 8'($urandom_range(8'h41, 8'h5A));
        end
        else if (shape > 6)
        begin
            repeat ($urandom_range(0, 6)) txt.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        body_len = ($urandom_range(0, 24) == 0) ? $urandom_range(110, 135)
                                                 : $urandom_range(0, 20);
        repeat (body_len) txt.push_back(payload_char());
        sum = 8'h00;
        foreach (txt[i]) sum ^= txt[i];
        lower = 1'($urandom_range(0, 1));
        send_byte(CH_DOLLAR);
        foreach (txt[i]) send_byte(txt[i]);
        tail = $urandom_range(0, 15);
        case (tail)
            7:
            begin
                send_byte(CH_STAR);
                junk = sum ^ 8'($urandom_range(1, 255));
                send_byte(hex_char(junk[7:4], lower));
                send_byte(hex_char(junk[3:0], lower));
                send_byte(CH_NL);
            end
            8:
            begin
                send_byte(CH_STAR);
                send_byte(hex_char(($urandom_range(0, 1) ? sum[3:0] : sum[7:4]), lower));
                send_byte(CH_NL);
            end
            9:
            begin
                send_byte(CH_STAR);
                send_byte(CH_NL);
            end
            10: send_byte(CH_NL);
            11:
            begin
                send_byte(CH_STAR);
                send_byte(bad_lead[$urandom_range(0, bad_lead.len() - 1)]);
                send_byte(hex_char(sum[7:4], lower));
                send_byte(hex_char(sum[3:0], lower));
                send_byte(CH_NL);
            end
            12:
            begin
                send_byte(CH_STAR);
                send_byte(hex_char(sum[7:4], lower));
                send_byte(hex_char(sum[3:0], lower));
                send_byte(CH_STAR);
                send_byte(payload_char());
                send_byte(CH_NL);
            end
            13: ;
            14:
            begin
                send_byte(CH_STAR);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
                send_byte(CH_NL);
            end
            default:
            begin
                send_byte(CH_STAR);
                send_byte(hex_char(sum[7:4], lower));
                send_byte(hex_char(sum[3:0], !lower));
                if ($urandom_range(0, 1)) send_byte(8'h0D);
                send_byte(CH_NL);
            end
        endcase
    endtask

    initial
    begin
        int  random_start;
        bit  mid_pause_done;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_nmea("GPGGA,123519,4807.038,N", 1'b0);
        send_nmea("GNGGA,", 1'b1);
        send_nmea("GPRMC,A", 1'b0);
        send_nmea("GNRMC,V", 1'b1);
        send_text("$GPGSV,1*00\n");
        send_text("$GP\n");
        send_text("$GPGGA,no star\n");
        send_text("$A*\n");
        send_text("$AB*3\n");
        send_text("$B*+2\n");
        send_text("$B*0x42\n");
        send_text("$B* 42\n");
        send_text("$B*4G\n");
        send_byte(CH_DOLLAR);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("*7f\n");
        send_text("abc\n");
        send_text("$GPRMC,12");
        send_nmea("GNGGA,2", 1'b0);
        send_byte(CH_DOLLAR);
        repeat (MAX_LEN - 2) send_byte("x");
        send_byte(CH_NL);
        send_byte(CH_DOLLAR);
        repeat (MAX_LEN - 1) send_byte("x");
        send_byte(CH_NL);
        send_text("*00\n");

        wait_drained();
        hold_request   = 1'b1;
        random_start   = bytes_sent;
        mid_pause_done = 1'b0;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_random_sentence();
            end
            if (!mid_pause_done && bytes_sent - random_start > RANDOM_BYTES / 2)
            begin
                wait_drained();
                mid_pause_done = 1'b1;
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        sentences.flag_leftovers();
        if (sentences.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hw/rtl/nsfc_pkg.sv
hw/rtl/nsfc_front.sv
hw/rtl/nsfc_queue.sv
hw/rtl/nsfc_back.sv
hw/rtl/nsfc_sentence_framer_checksum.sv
test/nmea_sentence_framer_checksum_tb.sv
